### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tilt stepper drive checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcsd assertion failed");

// next-cycle implication
`define TCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcsd assertion failed");

`endif

### hw/rtl/tcsd_pkg.sv
// ----------------------------------------------------------------------------
// tcsd_pkg
// Types and constants for the tilt estimator and stepper phase drive.
// ----------------------------------------------------------------------------
package tcsd_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_STEPS        = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_STEPS) ?
                                     CORDIC_ITERATIONS : ATAN_STEPS;
  localparam int STEP_W            = $clog2(ATAN_STEPS);

  localparam int SAMPLE_W   = 16;
  localparam int TARGET_W   = 17;
  localparam int PITCH_W    = 18;
  localparam int DELAY_W    = 7;
  localparam int PHASE_W    = 4;
  localparam int ANGLE_W    = 18;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  localparam int OUT_DELAY_LSB = PHASE_W;
  localparam int OUT_PITCH_LSB = PHASE_W + DELAY_W;

  localparam int PITCH_LIMIT = 92160;
  localparam int FORCE_LIMIT = 32768;

  localparam int DELAY_NEAR = 100;
  localparam int DELAY_ONE  = 5;
  localparam int DELAY_TWO  = 2;
  localparam int DELAY_FAR  = 1;

  localparam logic signed [TARGET_W-1:0] TARGET_RESET = 17'sd3840;
  localparam logic [PHASE_W-1:0]         PHASE_RESET  = 4'b0011;

  // shared reciprocal divider
  localparam int DIV_NUM_W  = 30;
  localparam int DIV_Q_W    = 17;
  localparam int GYRO_DEN   = 131000;
  localparam int GYRO_HALF  = 65500;
  localparam int BLEND_DEN  = 25;
  localparam int BLEND_HALF = 12;

  // 131000 = 8 * 16375: drop three bits, then multiply by 1/16375
  localparam int GYRO_PRE = 3;
  localparam int GYRO_ODD = GYRO_DEN >> GYRO_PRE;
  localparam int GYRO_SH  = 41;
  localparam int BLEND_SH = 27;
  localparam longint GYRO_RECIP  = ((longint'(1) << GYRO_SH) + longint'(GYRO_ODD) - 1)
                                   / longint'(GYRO_ODD);
  localparam longint BLEND_RECIP = ((longint'(1) << BLEND_SH) + longint'(BLEND_DEN) - 1)
                                   / longint'(BLEND_DEN);
  localparam int MUL_A_W = DIV_NUM_W - GYRO_PRE;
  localparam int MUL_B_W = 28;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic {
    DIV_GYRO,
    DIV_BLEND
  } div_mode_t;

  typedef struct packed {
    logic      start;
    div_mode_t mode;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GDIV_GO,
    ST_GDIV,
    ST_CORD,
    ST_BDIV_GO,
    ST_BDIV,
    ST_FIN
  } tcsd_state_t;

endpackage

### hw/rtl/tcsd_div.sv
// ----------------------------------------------------------------------------
// tcsd_div
// Division by a fixed constant through a reciprocal multiply; the operand is
// registered, then the shifted product is registered as the quotient.
// ----------------------------------------------------------------------------
module tcsd_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tcsd_pkg::div_req_t             req,
  input  logic [tcsd_pkg::DIV_NUM_W-1:0] dividend,
  output logic                           done,
  output logic [tcsd_pkg::DIV_Q_W-1:0]   quotient
);
  import tcsd_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  div_mode_t          mode_r, mode_nxt;
  logic [MUL_A_W-1:0] opa_r, opa_nxt;
  logic [DIV_Q_W-1:0] quo_r, quo_nxt;
  logic [MUL_B_W-1:0] recip;
  logic [MUL_P_W-1:0] prod;

  always_comb begin
    recip    = (mode_r == DIV_GYRO) ? MUL_B_W'(GYRO_RECIP) : MUL_B_W'(BLEND_RECIP);
    prod     = MUL_P_W'(opa_r) * MUL_P_W'(recip);
    busy_nxt = 1'b0;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    opa_nxt  = opa_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      mode_nxt = req.mode;
      unique case (req.mode)
        DIV_GYRO:  opa_nxt = MUL_A_W'(dividend >> GYRO_PRE);
        DIV_BLEND: opa_nxt = MUL_A_W'(dividend);
        default:   busy_nxt = 1'b0;
      endcase
    end else if (busy_r) begin
      done_nxt = 1'b1;
      unique case (mode_r)
        DIV_GYRO:  quo_nxt = DIV_Q_W'(prod >> GYRO_SH);
        DIV_BLEND: quo_nxt = DIV_Q_W'(prod >> BLEND_SH);
        default:   quo_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    opa_r  <= opa_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/tcsd_cordic.sv
// ----------------------------------------------------------------------------
// tcsd_cordic
// Vectoring CORDIC, one micro-rotation per cycle, angle in 1/256 degree.
// ----------------------------------------------------------------------------
module tcsd_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [tcsd_pkg::SAMPLE_W-1:0] accel_x,
  input  logic signed [tcsd_pkg::SAMPLE_W-1:0] accel_y,
  output logic                                done,
  output logic signed [tcsd_pkg::ANGLE_W-1:0]  angle
);
  import tcsd_pkg::*;

  localparam int VEC_W  = 35;
  localparam int Z_W    = 26;
  localparam int ATAN_W = 22;

  localparam logic signed [Z_W-1:0] Z_QUARTER = 26'sd5898240;
  localparam logic signed [Z_W-1:0] Z_HALF    = 26'sd128;

  function automatic logic [ATAN_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
    case (idx)
      0:       return 22'd2949120;
      1:       return 22'd1740967;
      2:       return 22'd919879;
      3:       return 22'd466945;
      4:       return 22'd234379;
      5:       return 22'd117304;
      6:       return 22'd58666;
      7:       return 22'd29335;
      8:       return 22'd14668;
      9:       return 22'd7334;
      10:      return 22'd3667;
      11:      return 22'd1833;
      12:      return 22'd917;
      13:      return 22'd458;
      14:      return 22'd229;
      15:      return 22'd115;
      16:      return 22'd57;
      17:      return 22'd29;
      18:      return 22'd14;
      19:      return 22'd7;
      20:      return 22'd4;
      21:      return 22'd2;
      22:      return 22'd1;
      default: return 22'd0;
    endcase
  endfunction

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic signed [VEC_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]   z_r, z_nxt;
  logic signed [VEC_W-1:0] x0, y0, xs, ys;
  logic signed [Z_W-1:0]   at, z_rnd;

  always_comb begin
    x0       = VEC_W'($signed({accel_y, 16'h0000}));
    y0       = VEC_W'($signed({accel_x, 16'h0000}));
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    at       = $signed(Z_W'(atan_step(cnt_r)));
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      cnt_nxt = '0;
      if (accel_x == '0 && accel_y == '0) begin
        z_nxt    = '0;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        if (accel_y[SAMPLE_W-1] && !accel_x[SAMPLE_W-1]) begin
          x_nxt = y0;
          y_nxt = -x0;
          z_nxt = Z_QUARTER;
        end else if (accel_y[SAMPLE_W-1]) begin
          x_nxt = -y0;
          y_nxt = x0;
          z_nxt = -Z_QUARTER;
        end else begin
          x_nxt = x0;
          y_nxt = y0;
          z_nxt = '0;
        end
      end
    end else if (busy_r) begin
      if (!y_r[VEC_W-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end
      if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign z_rnd = z_r + Z_HALF;
  assign angle = z_rnd[Z_W-1 -: ANGLE_W];
  assign done  = done_r;

endmodule

### hw/rtl/tilt_complementary_stepper_drive.sv
// ----------------------------------------------------------------------------
// tilt_complementary_stepper_drive
// Complementary-filter pitch estimate and stepper coil phase drive.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload (low bit first)
// in_      slave      accel_x, accel_y, accel_z, gyro_z (4 x 16 bit, signed)
// out_     master     step_pattern (4), step_delay_ms (7), pitch_estimate (18 s)
// cfg_     write      target_angle (17 bit, signed)
//
// An item runs a reciprocal multiply for the gyro step, 16 CORDIC iterations
// and a reciprocal multiply for the blend on the shared units; the CORDIC and
// the blend are skipped when the sum of the accel magnitudes reaches the force
// limit, and a zero accel vector skips the CORDIC iterations.
// in_tready is high only in idle; a finished item waits in the output
// register, and the block accepts the next item meanwhile. The final state
// holds while that register is full and out_tready is low.
// Reset (synchronous, active low) clears pitch to 0, the phase to 0011 and the
// target to 15 degrees.
// ----------------------------------------------------------------------------
module tilt_complementary_stepper_drive (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tcsd_pkg::TARGET_W-1:0]   cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // accel_x, accel_y, accel_z, gyro_z
  input  logic [tcsd_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // step_pattern, step_delay_ms, pitch_estimate, zero fill
  output logic [tcsd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tcsd_pkg::*;

  localparam int PROD_W  = 23;
  localparam int BLEND_W = 23;
  localparam int SUM_W   = 20;
  localparam int FORCE_W = 19;

  function automatic logic [DELAY_W-1:0] delay_of(
    input logic signed [TARGET_W-1:0] tgt,
    input logic signed [PITCH_W-1:0]  p
  );
    logic signed [PITCH_W:0] d;
    logic [PITCH_W:0]        mag;
    logic [PITCH_W-8:0]      e;
    d   = (PITCH_W+1)'(tgt) - (PITCH_W+1)'(p);
    mag = d[PITCH_W] ? unsigned'(-d) : unsigned'(d);
    e   = mag[PITCH_W:8];
    if (e == '0)
      return DELAY_W'(DELAY_NEAR);
    else if (e == (PITCH_W-7)'(1))
      return DELAY_W'(DELAY_ONE);
    else if (e == (PITCH_W-7)'(2))
      return DELAY_W'(DELAY_TWO);
    else
      return DELAY_W'(DELAY_FAR);
  endfunction

  function automatic logic signed [PITCH_W-1:0] sat_pitch(
    input logic signed [SUM_W-1:0] v
  );
    if (v > PITCH_LIMIT)
      return PITCH_W'(PITCH_LIMIT);
    else if (v < -PITCH_LIMIT)
      return PITCH_W'(-PITCH_LIMIT);
    else
      return PITCH_W'(v);
  endfunction

  function automatic logic [SAMPLE_W:0] abs_s(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W:0] w;
    w = (SAMPLE_W+1)'(v);
    return w[SAMPLE_W] ? unsigned'(-w) : unsigned'(w);
  endfunction

  tcsd_state_t state_r, state_nxt;

  logic signed [TARGET_W-1:0] target_r;
  logic signed [PITCH_W-1:0]  pitch_r;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic signed [SAMPLE_W-1:0] ax_r, ay_r, az_r, gz_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [BLEND_W-1:0]  blend_r;
  logic                       force_ok_r;
  logic                       neg_r;
  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r;

  logic                       in_fire, fin_go;
  div_req_t                   div_req;
  logic [DIV_NUM_W-1:0]       div_num;
  logic                       div_done;
  logic [DIV_Q_W-1:0]         div_quo;
  logic                       cord_start, cord_done;
  logic signed [ANGLE_W-1:0]  cord_angle;
  logic [PROD_W-1:0]          prod_abs;
  logic [BLEND_W-1:0]         blend_abs;
  logic signed [SUM_W-1:0]    q_mag, q_signed;
  logic [FORCE_W-1:0]         force_sum;
  logic signed [7:0]          delay_s;

  assign in_fire   = in_tvalid && in_tready;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign prod_abs  = prod_r[PROD_W-1] ? unsigned'(-prod_r) : unsigned'(prod_r);
  assign blend_abs = blend_r[BLEND_W-1] ? unsigned'(-blend_r) : unsigned'(blend_r);
  assign q_mag     = SUM_W'($signed({1'b0, div_quo}));
  assign q_signed  = neg_r ? -q_mag : q_mag;
  assign force_sum = FORCE_W'(abs_s(ax_r)) + FORCE_W'(abs_s(ay_r)) + FORCE_W'(abs_s(az_r));
  assign delay_s   = $signed({1'b0, delay_of(target_r, pitch_r)});
  assign phase_nxt = (pitch_r > PITCH_W'(target_r)) ? {phase_r[PHASE_W-2:0], phase_r[PHASE_W-1]}
                                                    : {phase_r[0], phase_r[PHASE_W-1:1]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_GDIV_GO;
      ST_GDIV_GO: state_nxt = ST_GDIV;
      ST_GDIV:    if (div_done) state_nxt = force_ok_r ? ST_CORD : ST_FIN;
      ST_CORD:    if (cord_done) state_nxt = ST_BDIV_GO;
      ST_BDIV_GO: state_nxt = ST_BDIV;
      ST_BDIV:    if (div_done) state_nxt = ST_FIN;
      ST_FIN:     if (fin_go) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    div_req.start = 1'b0;
    div_req.mode  = DIV_GYRO;
    div_num       = DIV_NUM_W'({prod_abs, 8'h00}) + DIV_NUM_W'(GYRO_HALF);
    cord_start    = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_GDIV_GO: div_req.start = 1'b1;
      ST_GDIV:    cord_start = div_done && force_ok_r;
      ST_BDIV_GO: begin
        div_req.start = 1'b1;
        div_req.mode  = DIV_BLEND;
        div_num       = DIV_NUM_W'(blend_abs) + DIV_NUM_W'(BLEND_HALF);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= TARGET_RESET;
      pitch_r     <= '0;
      phase_r     <= PHASE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we)
        target_r <= cfg_wdata;
      if (state_r == ST_GDIV && div_done)
        pitch_r <= sat_pitch(SUM_W'(pitch_r) + q_signed);
      else if (state_r == ST_BDIV && div_done)
        pitch_r <= sat_pitch(q_signed);
      if (fin_go)
        phase_r <= phase_nxt;
      if (fin_go)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r <= in_tdata[SAMPLE_W-1:0];
      ay_r <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      az_r <= in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
      gz_r <= in_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
    end
    if (state_r == ST_MUL) begin
      prod_r     <= PROD_W'(gz_r) * PROD_W'(delay_s);
      force_ok_r <= force_sum < FORCE_W'(FORCE_LIMIT);
    end
    if (state_r == ST_GDIV_GO)
      neg_r <= prod_r[PROD_W-1];
    else if (state_r == ST_BDIV_GO)
      neg_r <= blend_r[BLEND_W-1];
    if (state_r == ST_CORD && cord_done)
      blend_r <= (BLEND_W'(pitch_r) <<< 4) + (BLEND_W'(pitch_r) <<< 3) + BLEND_W'(cord_angle);
    if (fin_go)
      out_data_r <= OUT_DATA_W'({pitch_r, delay_of(target_r, pitch_r), phase_nxt});
  end

  tcsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_num),
    .done     (div_done),
    .quotient (div_quo)
  );

  tcsd_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cord_start),
    .accel_x (ax_r),
    .accel_y (ay_r),
    .done    (cord_done),
    .angle   (cord_angle)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hw/rtl/tcsd_check.sv
// ----------------------------------------------------------------------------
// tcsd_check
// Port-level checks for the tilt stepper drive, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcsd_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tcsd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tcsd_pkg::*;

  logic [DELAY_W-1:0] dly;
  logic [PHASE_W-1:0] pat;

  assign dly = out_tdata[OUT_DELAY_LSB +: DELAY_W];
  assign pat = out_tdata[PHASE_W-1:0];

  `TCSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `TCSD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `TCSD_ASSERT_NOW(a_delay_code, clk, rst_n, out_tvalid, dly == DELAY_W'(DELAY_NEAR) || dly == DELAY_W'(DELAY_ONE) || dly == DELAY_W'(DELAY_TWO) || dly == DELAY_W'(DELAY_FAR))
  `TCSD_ASSERT_NOW(a_two_coils, clk, rst_n, out_tvalid, $countones(pat) == 2)
  `TCSD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

bind tilt_complementary_stepper_drive tcsd_check u_tcsd_check (.*);
